### design/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

  localparam logic [7:0] BYTE_INTR  = 8'h03;
  localparam logic [7:0] BYTE_START = 8'h24;
  localparam logic [7:0] BYTE_HASH  = 8'h23;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_INTR = 2'd2
  } dpd_kind_t;

  typedef struct packed {
    logic       valid;
    dpd_kind_t  kind;
    logic [7:0] value;
    logic       bad_digit;
    logic       last;
  } dpd_res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } dpd_hex_t;

  function automatic dpd_hex_t hex_decode(input logic [7:0] c);
    dpd_hex_t h;
    h.bad = 1'b0;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### design/dpd_fsm.sv
`default_nettype none

module dpd_fsm
  import dpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output dpd_res_t        res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CKHI = 2'd2,
    PH_CKLO = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] hi_nib_r, hi_nib_nxt;
  logic       dig_err_r, dig_err_nxt;
  dpd_hex_t   hex;

  assign hex = hex_decode(rx_byte);

  always_comb begin
    phase_nxt     = phase_r;
    hi_nib_nxt    = hi_nib_r;
    dig_err_nxt   = dig_err_r;
    res.valid     = 1'b0;
    res.kind      = KIND_DATA;
    res.value     = rx_byte;
    res.bad_digit = 1'b0;
    res.last      = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == BYTE_INTR) begin
          res.valid = 1'b1;
          res.kind  = KIND_INTR;
          res.value = BYTE_INTR;
        end else if (rx_byte == BYTE_START) begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_byte == BYTE_HASH) begin
          phase_nxt   = PH_CKHI;
          hi_nib_nxt  = 4'd0;
          dig_err_nxt = 1'b0;
        end else begin
          res.valid = 1'b1;
        end
      end
      PH_CKHI: begin
        hi_nib_nxt  = hex.nib;
        dig_err_nxt = hex.bad;
        phase_nxt   = PH_CKLO;
      end
      PH_CKLO: begin
        res.valid     = 1'b1;
        res.kind      = KIND_END;
        res.value     = {hi_nib_r, hex.nib};
        res.bad_digit = dig_err_r | hex.bad;
        res.last      = 1'b1;
        phase_nxt     = PH_IDLE;
        hi_nib_nxt    = 4'd0;
        dig_err_nxt   = 1'b0;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hi_nib_r  <= 4'd0;
      dig_err_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      hi_nib_r  <= hi_nib_nxt;
      dig_err_r <= dig_err_nxt;
    end
  end

`ifndef SYNTH
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_CKLO |=> phase_r == PH_IDLE && hi_nib_r == 4'd0 && !dig_err_r)
    else $error("state not cleared after packet end");

  a_intr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == KIND_INTR |-> phase_r == PH_IDLE && res.value == BYTE_INTR)
    else $error("interrupt outside idle phase");

  a_hash_enters_ck: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_BODY && rx_byte == BYTE_HASH |=> phase_r == PH_CKHI && !dig_err_r)
    else $error("hash did not start checksum");

  a_ck_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CKHI |-> !res.valid)
    else $error("result during high checksum digit");
`endif

endmodule

`default_nettype wire

### design/debug_packet_deframer.sv
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_rx_byte[7:0]
// out      out  out_valid/out_stall out_kind[1:0] out_value[7:0] out_bad_digit out_last
//
// One byte per cycle while out_stall is low: a byte is decoded in the cycle
// it is accepted and its result appears in the output register on the next cycle.
// Throughput is one item per cycle while out_stall is low.
// in_stall is high only while the output register holds an item and out_stall is high.
// Synchronous active-low reset returns the deframer to the between-packet phase.
`default_nettype none

module debug_packet_deframer
  import dpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic            out_bad_digit,
  output logic            out_last
);

  dpd_res_t   res;
  logic       take;
  logic       out_valid_r;
  dpd_kind_t  kind_r;
  logic [7:0] value_r;
  logic       bad_r;
  logic       last_r;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  dpd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= take && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      kind_r  <= res.kind;
      value_r <= res.value;
      bad_r   <= res.bad_digit;
      last_r  <= res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_value     = value_r;
  assign out_bad_digit = bad_r;
  assign out_last      = last_r;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.valid |=> out_valid_r)
    else $error("result lost");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_last == (out_kind == KIND_END))
    else $error("last flag mismatch");
`endif

endmodule

`default_nettype wire

### verif/debug_packet_deframer_tb.sv
`timescale 1ns / 100ps

module debug_packet_deframer_tb;
  import dpd_pkg::*;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_BODY,
    LINK_CKHI,
    LINK_CKLO
  } link_phase_t;

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_TYPED,
    CHK_PREDICTED
  } check_mode_t;

  typedef struct packed {
    dpd_kind_t  kind;
    logic [7:0] value;
    logic       bad_digit;
    logic       last;
  } deframed_t;

  typedef struct packed {
    logic [7:0]  rx;
    check_mode_t mode;
    deframed_t   res;
  } byte_row_t;

  localparam int NUM_ROWS = 24;
  localparam int RANDOM_ITEMS = 800;
  localparam deframed_t NO_RES = '0;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_bad_digit;
  logic       out_last;

  debug_packet_deframer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_bad_digit(out_bad_digit),
    .out_last     (out_last)
  );

  always #2 clk = ~clk;

  link_phase_t link_phase;
  logic [3:0]  ck_high;
  logic        ck_error;
  deframed_t   deframed_q[$];
  byte_row_t   directed_rows[NUM_ROWS];
  bit          no_idle;
  int          fail_count;
  int          items_sent;
  int          results_seen;
  int          ends_seen;
  int          intrs_seen;
  int          bad_ends_seen;

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // {bad, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, 4'(c - "0")};
    end
    if (c >= "a" && c <= "f") begin
      return {1'b0, 4'(c - "a" + 8'd10)};
    end
    if (c >= "A" && c <= "F") begin
      return {1'b0, 4'(c - "A" + 8'd10)};
    end
    return 5'h10;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output deframed_t r);
    logic [4:0] h;
    bit         has;
    has = 1'b0;
    r = NO_RES;
    case (link_phase)
      LINK_IDLE: begin
        if (b == BYTE_INTR) begin
          has = 1'b1;
          r.kind = KIND_INTR;
          r.value = BYTE_INTR;
        end else if (b == BYTE_START) begin
          link_phase = LINK_BODY;
        end
      end
      LINK_BODY: begin
        if (b == BYTE_HASH) begin
          link_phase = LINK_CKHI;
          ck_high = 4'd0;
          ck_error = 1'b0;
        end else begin
          has = 1'b1;
          r.kind = KIND_DATA;
          r.value = b;
        end
      end
      LINK_CKHI: begin
        h = hex_value(b);
        ck_high = h[3:0];
        ck_error = h[4];
        link_phase = LINK_CKLO;
      end
      default: begin
        h = hex_value(b);
        has = 1'b1;
        r.kind = KIND_END;
        r.value = {ck_high, h[3:0]};
        r.bad_digit = ck_error | h[4];
        r.last = 1'b1;
        link_phase = LINK_IDLE;
        ck_high = 4'd0;
        ck_error = 1'b0;
      end
    endcase
    return has;
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return 8'("0" + k);
    end
    if (k < 16) begin
      return 8'("a" + k - 10);
    end
    return 8'("A" + k - 16);
  endfunction

  task automatic send_byte(input logic [7:0] b, input check_mode_t mode,
                           input deframed_t typed);
    deframed_t r;
    bit        has;
    repeat (idle_cycles()) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    has = deframe_byte(b, r);
    if (mode == CHK_TYPED) begin
      deframed_q.push_back(typed);
    end else if (mode == CHK_PREDICTED && has) begin
      deframed_q.push_back(r);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    int         n;
    int         k;
    logic [7:0] b;
    n = $urandom_range(0, 3);
    repeat (n) begin
      k = $urandom_range(0, 5);
      b = (k == 0) ? BYTE_INTR : (k == 1) ? BYTE_HASH : 8'($urandom);
      send_byte(b, CHK_PREDICTED, NO_RES);
    end
  endtask

  task automatic send_packet();
    int         len;
    int         k;
    logic [7:0] b;
    send_byte(BYTE_START, CHK_PREDICTED, NO_RES);
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    repeat (len) begin
      k = $urandom_range(0, 9);
      b = (k == 0) ? BYTE_INTR : (k == 1) ? BYTE_START : 8'($urandom);
      send_byte(b, CHK_PREDICTED, NO_RES);
    end
    // drop the trailer now and then
    if ($urandom_range(0, 15) != 0) begin
      send_byte(BYTE_HASH, CHK_PREDICTED, NO_RES);
      repeat (2) begin
        b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : hex_char();
        send_byte(b, CHK_PREDICTED, NO_RES);
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    rst_n = 1'b0;
    no_idle = 1'b0;
    link_phase = LINK_IDLE;
    ck_high = 4'd0;
    ck_error = 1'b0;
    directed_rows = '{
      '{BYTE_INTR,  CHK_TYPED,     '{KIND_INTR, 8'h03, 1'b0, 1'b0}},
      '{BYTE_HASH,  CHK_NONE,      NO_RES},
      '{8'h00,      CHK_NONE,      NO_RES},
      '{8'hFF,      CHK_NONE,      NO_RES},
      '{BYTE_START, CHK_NONE,      NO_RES},
      '{BYTE_INTR,  CHK_TYPED,     '{KIND_DATA, 8'h03, 1'b0, 1'b0}},
      '{BYTE_START, CHK_TYPED,     '{KIND_DATA, 8'h24, 1'b0, 1'b0}},
      '{8'hFF,      CHK_TYPED,     '{KIND_DATA, 8'hFF, 1'b0, 1'b0}},
      '{8'h00,      CHK_TYPED,     '{KIND_DATA, 8'h00, 1'b0, 1'b0}},
      '{BYTE_HASH,  CHK_NONE,      NO_RES},
      '{"F",        CHK_NONE,      NO_RES},
      '{"f",        CHK_TYPED,     '{KIND_END,  8'hFF, 1'b0, 1'b1}},
      '{BYTE_START, CHK_NONE,      NO_RES},
      '{BYTE_HASH,  CHK_NONE,      NO_RES},
      '{BYTE_START, CHK_NONE,      NO_RES},
      '{"9",        CHK_PREDICTED, NO_RES},
      '{BYTE_START, CHK_NONE,      NO_RES},
      '{BYTE_HASH,  CHK_NONE,      NO_RES},
      '{"a",        CHK_NONE,      NO_RES},
      '{BYTE_INTR,  CHK_PREDICTED, NO_RES},
      '{BYTE_START, CHK_NONE,      NO_RES},
      '{BYTE_HASH,  CHK_NONE,      NO_RES},
      '{"0",        CHK_NONE,      NO_RES},
      '{BYTE_HASH,  CHK_TYPED,     '{KIND_END,  8'h00, 1'b1, 1'b1}}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].mode, directed_rows[i].res);
    end
    drain_results();

    while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end
      send_noise();
      send_packet();
    end
    drain_results();

    no_idle = 1'b1;
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes; checked %0d results (%0d packet ends,",
             items_sent, results_seen, ends_seen);
    $display("%0d with bad digits, %0d interrupts).", bad_ends_seen, intrs_seen);
    if (fail_count == 0) begin
      $display("** debug_packet_deframer: PASSED **");
    end else begin
      $display("** debug_packet_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    deframed_t want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      repeat (idle_cycles()) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (out_kind == KIND_END) begin
        ends_seen++;
        if (out_bad_digit) bad_ends_seen++;
      end
      if (out_kind == KIND_INTR) intrs_seen++;
      if (deframed_q.size() == 0) begin
        $error("unexpected item: kind %0d value %02h", out_kind, out_value);
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_value !== want.value) begin
          $error("value: expected %02h, actual %02h", want.value, out_value);
          fail_count++;
        end
        if (out_bad_digit !== want.bad_digit) begin
          $error("bad_digit: expected %0b, actual %0b", want.bad_digit, out_bad_digit);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** debug_packet_deframer: FAILED **");
    $finish;
  end

endmodule
